// File: rtl/vt_pkg.sv
package vt_pkg;

  localparam int NUM_REGS  = 8;
  localparam int CFG_IDX_W = 4;

  localparam logic [1:0] KIND_POINT = 2'd0;
  localparam logic [1:0] KIND_VEC4  = 2'd1;
  localparam logic [1:0] KIND_DIR   = 2'd2;
  localparam logic [1:0] KIND_NONE  = 2'd3;

  localparam logic [31:0] FP_ONE      = 32'h3F80_0000;
  localparam logic [31:0] FP_NEG_ZERO = 32'h8000_0000;
  localparam logic [31:0] FP_DEF_NAN  = 32'hFFC0_0000;
  localparam logic [31:0] FP_QUIET    = 32'h0040_0000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] x_in;
    logic [31:0] y_in;
    logic [31:0] z_in;
    logic [31:0] w_in;
  } vin_t;

  typedef struct packed {
    logic [31:0] x_out;
    logic [31:0] y_out;
    logic [31:0] z_out;
    logic [31:0] w_out;
  } vout_t;

  typedef struct packed {
    logic               spc;
    logic [31:0]        spv;
    logic               sgn;
    logic signed [11:0] ex;
    logic [23:0]        m;
    logic [24:0]        r;
    logic [25:0]        q;
  } rcp_t;

  function automatic logic is_nan(input logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
  endfunction

  function automatic logic is_inf(input logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
  endfunction

  function automatic logic is_zero(input logic [31:0] a);
    return a[30:0] == 31'd0;
  endfunction

  function automatic logic [5:0] clz48(input logic [47:0] v);
    logic [5:0] n;
    n = 6'd48;
    for (int i = 0; i < 48; i++) begin
      if (v[i]) begin
        n = 6'(47 - i);
      end
    end
    return n;
  endfunction

  function automatic logic [4:0] clz28(input logic [27:0] v);
    logic [4:0] n;
    n = 5'd28;
    for (int i = 0; i < 28; i++) begin
      if (v[i]) begin
        n = 5'(27 - i);
      end
    end
    return n;
  endfunction

  // The significand carries its leading one at bit 26 and three bits below
  // the kept 24; the exponent is biased and may fall below the normal range.
  function automatic logic [31:0] round_pack(input logic sgn, input logic signed [11:0] ex,
                                             input logic [26:0] sig, input logic stk);
    logic [4:0]         sh;
    logic [58:0]        tmp;
    logic [26:0]        s2;
    logic               st2;
    logic [23:0]        m;
    logic               inc;
    logic [24:0]        mr;
    logic signed [11:0] e3;
    logic [31:0]        res;
    s2  = sig;
    st2 = stk;
    if (ex < 12'sd1) begin
      if (ex < -12'sd29) begin
        sh = 5'd31;
      end else begin
        sh = 5'(12'sd1 - ex);
      end
      tmp = {sig, 32'd0} >> sh;
      s2  = tmp[58:32];
      st2 = stk | (|tmp[31:0]);
    end
    m   = s2[26:3];
    inc = s2[2] & (s2[1] | s2[0] | st2 | m[0]);
    mr  = {1'b0, m} + 25'(inc);
    if (sig == 27'd0) begin
      res = {sgn, 31'd0};
    end else if (ex < 12'sd1) begin
      res = {sgn, 7'd0, mr[23], mr[22:0]};
    end else begin
      e3 = mr[24] ? ex + 12'sd1 : ex;
      if (e3 >= 12'sd255) begin
        res = {sgn, 8'hFF, 23'd0};
      end else begin
        res = {sgn, e3[7:0], mr[24] ? 23'd0 : mr[22:0]};
      end
    end
    return res;
  endfunction

endpackage

// File: rtl/vt_delay.sv
module vt_delay #(
  parameter int W = 32,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr [N];

  always_ff @(posedge clk) begin
    if (en) begin
      sr[0] <= d;
      for (int i = 1; i < N; i++) begin
        sr[i] <= sr[i-1];
      end
    end
  end

  assign q = sr[N-1];

endmodule

// File: rtl/vt_fmul.sv
module vt_fmul (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);

  logic               s1_spc;
  logic [31:0]        s1_spv;
  logic               s1_sgn;
  logic signed [11:0] s1_ex;
  logic [47:0]        s1_prod;

  logic               s2_spc;
  logic [31:0]        s2_spv;
  logic               s2_sgn;
  logic signed [11:0] s2_ex;
  logic [26:0]        s2_sig;
  logic               s2_stk;

  logic               spc;
  logic [31:0]        spv;
  logic [7:0]         ea;
  logic [7:0]         eb;
  logic [5:0]         lz;
  logic [47:0]        pn;

  always_comb begin
    ea  = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb  = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    spc = 1'b1;
    spv = {a[31] ^ b[31], 31'd0};
    if (vt_pkg::is_nan(a)) begin
      spv = a | vt_pkg::FP_QUIET;
    end else if (vt_pkg::is_nan(b)) begin
      spv = b | vt_pkg::FP_QUIET;
    end else if ((vt_pkg::is_inf(a) && vt_pkg::is_zero(b)) ||
                 (vt_pkg::is_inf(b) && vt_pkg::is_zero(a))) begin
      spv = vt_pkg::FP_DEF_NAN;
    end else if (vt_pkg::is_inf(a) || vt_pkg::is_inf(b)) begin
      spv = {a[31] ^ b[31], 8'hFF, 23'd0};
    end else if (!(vt_pkg::is_zero(a) || vt_pkg::is_zero(b))) begin
      spc = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_spc  <= spc;
      s1_spv  <= spv;
      s1_sgn  <= a[31] ^ b[31];
      s1_ex   <= $signed({4'd0, ea}) + $signed({4'd0, eb}) - 12'sd127;
      s1_prod <= {|a[30:23], a[22:0]} * {|b[30:23], b[22:0]};
    end
  end

  always_comb begin
    lz = vt_pkg::clz48(s1_prod);
    pn = s1_prod << lz;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_spc <= s1_spc;
      s2_spv <= s1_spv;
      s2_sgn <= s1_sgn;
      s2_ex  <= s1_ex + 12'sd1 - $signed({6'd0, lz});
      s2_sig <= pn[47:21];
      s2_stk <= |pn[20:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y <= s2_spc ? s2_spv : vt_pkg::round_pack(s2_sgn, s2_ex, s2_sig, s2_stk);
    end
  end

endmodule

// File: rtl/vt_fadd.sv
module vt_fadd (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);

  logic               s1_spc;
  logic [31:0]        s1_spv;
  logic               s1_sgn;
  logic               s1_sub;
  logic signed [11:0] s1_ex;
  logic [26:0]        s1_mb;
  logic [26:0]        s1_ms;

  logic               s2_spc;
  logic [31:0]        s2_spv;
  logic               s2_sgn;
  logic signed [11:0] s2_ex;
  logic [27:0]        s2_sum;
  logic [4:0]         s2_lz;

  logic               spc;
  logic [31:0]        spv;
  logic [31:0]        big;
  logic [31:0]        sml;
  logic [7:0]         eb;
  logic [7:0]         es;
  logic [7:0]         d;
  logic [4:0]         sh;
  logic [58:0]        tmp;
  logic [27:0]        sum;
  logic [4:0]         nsh;
  logic [27:0]        sn;

  always_comb begin
    spc = 1'b1;
    spv = {a[31] & b[31], 31'd0};
    if (vt_pkg::is_nan(a)) begin
      spv = a | vt_pkg::FP_QUIET;
    end else if (vt_pkg::is_nan(b)) begin
      spv = b | vt_pkg::FP_QUIET;
    end else if (vt_pkg::is_inf(a) && vt_pkg::is_inf(b) && (a[31] != b[31])) begin
      spv = vt_pkg::FP_DEF_NAN;
    end else if (vt_pkg::is_inf(a)) begin
      spv = a;
    end else if (vt_pkg::is_inf(b)) begin
      spv = b;
    end else if (!(vt_pkg::is_zero(a) && vt_pkg::is_zero(b))) begin
      spc = 1'b0;
    end
    if (b[30:0] > a[30:0]) begin
      big = b;
      sml = a;
    end else begin
      big = a;
      sml = b;
    end
    eb  = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    es  = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    d   = eb - es;
    sh  = (d > 8'd31) ? 5'd31 : d[4:0];
    tmp = {|sml[30:23], sml[22:0], 3'd0, 32'd0} >> sh;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_spc <= spc;
      s1_spv <= spv;
      s1_sgn <= big[31];
      s1_sub <= a[31] ^ b[31];
      s1_ex  <= $signed({4'd0, eb});
      s1_mb  <= {|big[30:23], big[22:0], 3'd0};
      s1_ms  <= tmp[58:32] | {26'd0, |tmp[31:0]};
    end
  end

  always_comb begin
    if (s1_sub) begin
      sum = {1'b0, s1_mb} - {1'b0, s1_ms};
    end else begin
      sum = {1'b0, s1_mb} + {1'b0, s1_ms};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_spc <= s1_spc;
      s2_spv <= s1_spv;
      s2_sgn <= s1_sgn;
      s2_ex  <= s1_ex;
      s2_sum <= sum;
      s2_lz  <= vt_pkg::clz28(sum);
    end
  end

  always_comb begin
    nsh = s2_lz - 5'd1;
    sn  = s2_sum << nsh;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (s2_spc) begin
        y <= s2_spv;
      end else if (s2_sum == 28'd0) begin
        y <= 32'd0;
      end else if (s2_sum[27]) begin
        y <= vt_pkg::round_pack(s2_sgn, s2_ex + 12'sd1, s2_sum[27:1], s2_sum[0]);
      end else begin
        y <= vt_pkg::round_pack(s2_sgn, s2_ex - $signed({7'd0, nsh}), sn[26:0], 1'b0);
      end
    end
  end

endmodule

// File: rtl/vt_frecip.sv
module vt_frecip (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  output logic [31:0] y
);

  localparam int NORM = 5;
  localparam int DIVB = 26;
  localparam int NST  = 1 + NORM + DIVB;

  vt_pkg::rcp_t st [NST];
  vt_pkg::rcp_t dec;

  function automatic vt_pkg::rcp_t nstep(input vt_pkg::rcp_t s, input int sh);
    vt_pkg::rcp_t o;
    o = s;
    if ((s.m >> (24 - sh)) == 24'd0) begin
      o.m  = s.m << sh;
      o.ex = s.ex - 12'(sh);
    end
    return o;
  endfunction

  function automatic vt_pkg::rcp_t dstep(input vt_pkg::rcp_t s, input logic first);
    vt_pkg::rcp_t o;
    logic [24:0]  rin;
    logic [25:0]  r2;
    logic         ge;
    o   = s;
    rin = first ? (25'h100_0000 - {1'b0, s.m}) : s.r;
    r2  = {rin, 1'b0};
    ge  = r2 >= {2'd0, s.m};
    o.r = ge ? 25'(r2 - {2'd0, s.m}) : r2[24:0];
    o.q = {s.q[24:0], ge};
    return o;
  endfunction

  function automatic logic [31:0] finish(input vt_pkg::rcp_t s);
    logic pow2;
    pow2 = s.m == 24'h80_0000;
    if (s.spc) begin
      return s.spv;
    end else if (pow2) begin
      return vt_pkg::round_pack(s.sgn, 12'sd254 - s.ex, 27'h400_0000, 1'b0);
    end else begin
      return vt_pkg::round_pack(s.sgn, 12'sd253 - s.ex, {1'b1, s.q}, s.r != 25'd0);
    end
  endfunction

  always_comb begin
    dec     = '0;
    dec.sgn = a[31];
    dec.m   = {|a[30:23], a[22:0]};
    dec.ex  = (a[30:23] == 8'd0) ? 12'sd1 : $signed({4'd0, a[30:23]});
    dec.spc = 1'b1;
    if (vt_pkg::is_nan(a)) begin
      dec.spv = a | vt_pkg::FP_QUIET;
    end else if (vt_pkg::is_inf(a)) begin
      dec.spv = {a[31], 31'd0};
    end else if (vt_pkg::is_zero(a)) begin
      dec.spv = vt_pkg::FP_ONE;
    end else begin
      dec.spc = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= dec;
      for (int k = 0; k < NORM; k++) begin
        st[k+1] <= nstep(st[k], 16 >> k);
      end
      for (int j = 0; j < DIVB; j++) begin
        st[NORM+1+j] <= dstep(st[NORM+j], j == 0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y <= finish(st[NST-1]);
    end
  end

endmodule

// File: rtl/vertex_transform_4x4_float.sv
// Channel  | Signals                        | Item
// ---------+--------------------------------+-------------------------------
// in       | in_valid, in_ready, in_data    | kind and x, y, z, w float32
// out      | out_valid, out_ready, out_data | x, y, z, w float32
// cfg      | cfg_we, cfg_index, cfg_data    | one 64-bit matrix column half
//
// One item enters every cycle unless the output stalls. The path runs
// through the products, the three chained adders, the pipelined
// reciprocal of w (one quotient bit per stage) and the final scale.
// Reset is synchronous, clears the valid bits and loads the identity
// matrix. A stall at the output freezes every stage at once, so in_ready
// is low exactly while a finished item waits.
module vertex_transform_4x4_float (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  vt_pkg::vin_t                 in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output vt_pkg::vout_t                out_data,
  input  logic                         cfg_we,
  input  logic [vt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                  cfg_data
);

  localparam int LAT = 48;
  localparam int TP  = 2;
  localparam int TI  = 44;

  logic [63:0] mat [vt_pkg::NUM_REGS];
  logic        en;
  logic [LAT-1:0] vld;
  logic [1:0]  knd [LAT];

  logic [31:0] el  [4][4];
  logic [31:0] vec [4];
  logic [31:0] p   [4][4];
  logic [31:0] p3m [4];
  logic [31:0] p2d [4];
  logic [31:0] p3d [4];
  logic [31:0] s1  [4];
  logic [31:0] s2  [4];
  logic [31:0] s3  [4];
  logic [31:0] s3d [4];
  logic [31:0] fo  [4];
  logic [31:0] rw;
  logic [31:0] iw;

  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      mat[0] <= {32'd0, vt_pkg::FP_ONE};
      mat[1] <= 64'd0;
      mat[2] <= {vt_pkg::FP_ONE, 32'd0};
      mat[3] <= 64'd0;
      mat[4] <= 64'd0;
      mat[5] <= {32'd0, vt_pkg::FP_ONE};
      mat[6] <= 64'd0;
      mat[7] <= {vt_pkg::FP_ONE, 32'd0};
    end else if (cfg_we && (cfg_index < vt_pkg::CFG_IDX_W'(vt_pkg::NUM_REGS))) begin
      mat[cfg_index[2:0]] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      knd[0] <= in_data.kind;
      for (int i = 1; i < LAT; i++) begin
        knd[i] <= knd[i-1];
      end
    end
  end

  assign vec[0] = in_data.x_in;
  assign vec[1] = in_data.y_in;
  assign vec[2] = in_data.z_in;
  assign vec[3] = (in_data.kind == vt_pkg::KIND_POINT) ? vt_pkg::FP_ONE : in_data.w_in;

  for (genvar c = 0; c < 4; c++) begin : g_col
    for (genvar r = 0; r < 4; r++) begin : g_row
      assign el[c][r] = mat[2*c + r/2][32*(r%2) +: 32];
      vt_fmul u_mul (.clk(clk), .en(en), .a(el[c][r]), .b(vec[c]), .y(p[c][r]));
    end
  end

  for (genvar r = 0; r < 4; r++) begin : g_dot
    assign p3m[r] = (knd[TP] == vt_pkg::KIND_DIR) ? vt_pkg::FP_NEG_ZERO : p[3][r];
    vt_delay #(.W(32), .N(3)) u_d2 (.clk(clk), .en(en), .d(p[2][r]), .q(p2d[r]));
    vt_delay #(.W(32), .N(6)) u_d3 (.clk(clk), .en(en), .d(p3m[r]), .q(p3d[r]));
    vt_fadd u_add1 (.clk(clk), .en(en), .a(p[0][r]), .b(p[1][r]), .y(s1[r]));
    vt_fadd u_add2 (.clk(clk), .en(en), .a(s1[r]), .b(p2d[r]), .y(s2[r]));
    vt_fadd u_add3 (.clk(clk), .en(en), .a(s2[r]), .b(p3d[r]), .y(s3[r]));
    vt_delay #(.W(32), .N(33)) u_ds (.clk(clk), .en(en), .d(s3[r]), .q(s3d[r]));
    vt_fmul u_scl (.clk(clk), .en(en), .a(s3d[r]), .b(iw), .y(fo[r]));
  end

  vt_frecip u_rcp (.clk(clk), .en(en), .a(s3[3]), .y(rw));

  assign iw = (knd[TI] == vt_pkg::KIND_POINT) ? rw : vt_pkg::FP_ONE;

  always_comb begin
    out_data = '0;
    if (knd[LAT-1] != vt_pkg::KIND_NONE) begin
      out_data.x_out = fo[0];
      out_data.y_out = fo[1];
      out_data.z_out = fo[2];
    end
    if (knd[LAT-1] == vt_pkg::KIND_VEC4) begin
      out_data.w_out = fo[3];
    end
  end

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("valid bits moved during a stall");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> vld[0])
    else $error("accepted item did not enter the pipeline");

  a_w_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (knd[LAT-1] != vt_pkg::KIND_VEC4) |-> out_data.w_out == 32'd0)
    else $error("w is not zero for a non vec4 item");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown straight after reset");
`endif

endmodule
